// ===== rtl/dtd_pkg.sv =====
// ----------------------------------------------------------------------------
// dtd_pkg
// Shared widths, codes, handshake types and helpers of the task dispatcher.
// ----------------------------------------------------------------------------
package dtd_pkg;

	localparam int DEF_MAX_TASKS = 32;

	localparam int MODE_W     = 2;
	localparam int REQ_W      = 5;
	localparam int ROW_W      = 32;
	localparam int RIDX_W     = 5;
	localparam int WIDX_W     = 6;
	localparam int TC_W       = 6;
	localparam int WC_W       = 7;
	localparam int OUT_W      = 2;
	localparam int ST_W       = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int OP_W       = 5;

	localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REBUILD = 2'd1;
	localparam logic [MODE_W-1:0] MODE_GET     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_END     = 2'd3;

	localparam logic [OUT_W-1:0] OUT_GIVEN = 2'd0;
	localparam logic [OUT_W-1:0] OUT_WAIT  = 2'd1;
	localparam logic [OUT_W-1:0] OUT_NONE  = 2'd2;
	localparam logic [OUT_W-1:0] OUT_ACK   = 2'd3;

	localparam logic [ST_W-1:0] ST_DONE       = 2'd0;
	localparam logic [ST_W-1:0] ST_INPROGRESS = 2'd1;
	localparam logic [ST_W-1:0] ST_AVAILABLE  = 2'd2;
	localparam logic [ST_W-1:0] ST_WAITING    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT = 2'd1;

	localparam logic [OP_W-1:0] OP_IDLE      = 5'd0;
	localparam logic [OP_W-1:0] OP_LATCH     = 5'd1;
	localparam logic [OP_W-1:0] OP_LOAD      = 5'd2;
	localparam logic [OP_W-1:0] OP_RB_INIT   = 5'd3;
	localparam logic [OP_W-1:0] OP_RB_READ   = 5'd4;
	localparam logic [OP_W-1:0] OP_RB_ROW    = 5'd5;
	localparam logic [OP_W-1:0] OP_GET_FWD   = 5'd6;
	localparam logic [OP_W-1:0] OP_RES_NONE  = 5'd7;
	localparam logic [OP_W-1:0] OP_RES_ACK   = 5'd8;
	localparam logic [OP_W-1:0] OP_DIV_START = 5'd9;
	localparam logic [OP_W-1:0] OP_SCAN_INIT = 5'd10;
	localparam logic [OP_W-1:0] OP_SCAN_STEP = 5'd11;
	localparam logic [OP_W-1:0] OP_END_INIT  = 5'd12;
	localparam logic [OP_W-1:0] OP_END_FIN   = 5'd13;
	localparam logic [OP_W-1:0] OP_NODE_READ = 5'd14;
	localparam logic [OP_W-1:0] OP_P1_INIT   = 5'd15;
	localparam logic [OP_W-1:0] OP_P1_STEP   = 5'd16;
	localparam logic [OP_W-1:0] OP_P2_INIT   = 5'd17;
	localparam logic [OP_W-1:0] OP_P2_STEP   = 5'd18;
	localparam logic [OP_W-1:0] OP_QUEUE     = 5'd19;
	localparam logic [OP_W-1:0] OP_OUT_LOAD  = 5'd20;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} dtd_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic fwd_valid;
		logic act_zero;
		logic act_le1;
		logic req_oob;
		logic rb_last;
		logic div_done;
		logic scan_hit;
		logic scan_last;
		logic node_end;
		logic mask_empty;
		logic wait_cur;
		logic p1_park;
		logic p2_park;
		logic out_free;
	} dtd_flags_t;

	// bits below position v set
	function automatic logic [ROW_W-1:0] low_mask(input logic [6:0] v);
		logic [ROW_W-1:0] m;
		for (int i = 0; i < ROW_W; i++) begin
			m[i] = (7'(i) < v);
		end
		return m;
	endfunction

	function automatic logic [RIDX_W-1:0] lowest_bit(input logic [ROW_W-1:0] r);
		logic [RIDX_W-1:0] idx;
		idx = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (r[i]) idx = RIDX_W'(i);
		end
		return idx;
	endfunction

endpackage

// ===== rtl/dependency_task_dispatcher_unit.sv =====
// ----------------------------------------------------------------------------
// dependency_task_dispatcher_unit
// Hands tasks of a dependency graph to workers in dependency order.
// ----------------------------------------------------------------------------
// One request is worked on at a time; each returns exactly one result beat.
// A load latches the request, writes its dependency row and loads the result.
// A rebuild resets the task states and lists, then does, per active task
// after the first, one dependency-row read and one list update. A get with
// a forwarded task hands that task out; otherwise the scan start is found by a
// bit-serial divider (worker index width plus count width steps) and the
// scan then tests one task status per cycle, up to the active task count.
// An end walks the closed watch list: per watcher a node read, a mask load
// and at most one step per set dependency bit below it, twice when a second
// search is needed. The single task-status read port keeps this serial.
// The result register lets the next request enter while a result is stalled.
module dependency_task_dispatcher_unit import dtd_pkg::*; #(
	parameter int MAX_TASKS = DEF_MAX_TASKS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [MODE_W-1:0]     mode,
	input  logic [REQ_W-1:0]      task_req,
	input  logic [ROW_W-1:0]      dep_row,
	input  logic [WIDX_W-1:0]     worker_index,
	input  logic                  forward_valid,
	input  logic [REQ_W-1:0]      forward_task,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [OUT_W-1:0]      outcome,
	output logic [REQ_W-1:0]      task_id,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dtd_cmd_t   cmd;
	dtd_flags_t flags;

	dtd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.flags    (flags),
		.cmd      (cmd)
	);

	dtd_dpath #(
		.MAX_TASKS(MAX_TASKS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.flags         (flags),
		.mode          (mode),
		.task_req      (task_req),
		.dep_row       (dep_row),
		.worker_index  (worker_index),
		.forward_valid (forward_valid),
		.forward_task  (forward_task),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.outcome       (outcome),
		.task_id       (task_id),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

endmodule

// ===== rtl/dtd_div.sv =====
// ----------------------------------------------------------------------------
// dtd_div
// Restoring divider, one quotient bit per cycle, for the scan start position.
// ----------------------------------------------------------------------------
module dtd_div import dtd_pkg::*; #(
	parameter int DVW = 12
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DVW-1:0]  dividend,
	input  logic [WC_W-1:0] divisor,
	output logic            done,
	output logic [DVW-1:0]  quotient
);

	localparam int CNT_W = $clog2(DVW + 1);

	logic [WC_W-1:0]  rem_q;
	logic [DVW-1:0]   quo_q;
	logic [WC_W-1:0]  div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [WC_W:0]    trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DVW-1]};
	assign fits  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			div_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				quo_q  <= dividend;
				div_q  <= divisor;
				cnt_q  <= CNT_W'(DVW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? WC_W'(trial - {1'b0, div_q}) : trial[WC_W-1:0];
				quo_q <= {quo_q[DVW-2:0], fits};
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/dtd_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtd_ctrl
// Sequencer: walks each request through its datapath operations.
// ----------------------------------------------------------------------------
module dtd_ctrl import dtd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dtd_flags_t flags,
	output dtd_cmd_t   cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_RB_RD  = 4'd2;
	localparam logic [3:0] S_RB_ROW = 4'd3;
	localparam logic [3:0] S_DIV    = 4'd4;
	localparam logic [3:0] S_SCAN   = 4'd5;
	localparam logic [3:0] S_NODE   = 4'd6;
	localparam logic [3:0] S_NODE_LD = 4'd7;
	localparam logic [3:0] S_P1     = 4'd8;
	localparam logic [3:0] S_P2     = 4'd9;
	localparam logic [3:0] S_FIN    = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_IDLE;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op  = OP_LATCH;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (flags.mode)
					MODE_LOAD: begin
						cmd.op  = OP_LOAD;
						state_d = S_FIN;
					end
					MODE_REBUILD: begin
						cmd.op  = OP_RB_INIT;
						state_d = flags.act_le1 ? S_FIN : S_RB_RD;
					end
					MODE_GET: begin
						priority if (flags.fwd_valid) begin
							cmd.op  = OP_GET_FWD;
							state_d = S_FIN;
						end else if (flags.act_zero) begin
							cmd.op  = OP_RES_NONE;
							state_d = S_FIN;
						end else begin
							cmd.op  = OP_DIV_START;
							state_d = S_DIV;
						end
					end
					default: begin
						if (flags.req_oob) begin
							cmd.op  = OP_RES_ACK;
							state_d = S_FIN;
						end else begin
							cmd.op  = OP_END_INIT;
							state_d = S_NODE;
						end
					end
				endcase
			end
			S_RB_RD: begin
				cmd.op  = OP_RB_READ;
				state_d = S_RB_ROW;
			end
			S_RB_ROW: begin
				cmd.op  = OP_RB_ROW;
				state_d = flags.rb_last ? S_FIN : S_RB_RD;
			end
			S_DIV: begin
				if (flags.div_done) begin
					cmd.op  = OP_SCAN_INIT;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.op = OP_SCAN_STEP;
				if (flags.scan_hit || flags.scan_last) state_d = S_FIN;
			end
			S_NODE: begin
				if (flags.node_end) begin
					cmd.op  = OP_END_FIN;
					state_d = S_FIN;
				end else begin
					cmd.op  = OP_NODE_READ;
					state_d = S_NODE_LD;
				end
			end
			S_NODE_LD: begin
				cmd.op  = OP_P1_INIT;
				state_d = S_P1;
			end
			S_P1: begin
				priority if (flags.mask_empty && flags.wait_cur) begin
					cmd.op  = OP_P2_INIT;
					state_d = S_P2;
				end else if (flags.mask_empty) begin
					cmd.op  = OP_QUEUE;
					state_d = S_NODE;
				end else begin
					cmd.op = OP_P1_STEP;
					if (flags.p1_park) state_d = S_NODE;
				end
			end
			S_P2: begin
				if (flags.mask_empty) begin
					cmd.op  = OP_QUEUE;
					state_d = S_NODE;
				end else begin
					cmd.op = OP_P2_STEP;
					if (flags.p2_park) state_d = S_NODE;
				end
			end
			S_FIN: begin
				if (flags.out_free) begin
					cmd.op  = OP_OUT_LOAD;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_div_to_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && flags.div_done) |=> (state_q == S_SCAN))
		else $error("divider result not followed by scan");

	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !flags.out_free) |=> (state_q == S_FIN))
		else $error("result left before output slot freed");

	a_park_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_P2 && !flags.mask_empty && flags.p2_park) |=> (state_q == S_NODE))
		else $error("parked watcher did not move to next node");

endmodule

// ===== rtl/dtd_dpath.sv =====
// ----------------------------------------------------------------------------
// dtd_dpath
// Task status, watch lists, dependency rows, scan counters and result slot.
// ----------------------------------------------------------------------------
module dtd_dpath import dtd_pkg::*; #(
	parameter int MAX_TASKS = DEF_MAX_TASKS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dtd_cmd_t              cmd,
	output dtd_flags_t            flags,
	input  logic [MODE_W-1:0]     mode,
	input  logic [REQ_W-1:0]      task_req,
	input  logic [ROW_W-1:0]      dep_row,
	input  logic [WIDX_W-1:0]     worker_index,
	input  logic                  forward_valid,
	input  logic [REQ_W-1:0]      forward_task,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [OUT_W-1:0]      outcome,
	output logic [REQ_W-1:0]      task_id,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int TW  = $clog2(MAX_TASKS);
	localparam int HW  = TW + 1;
	localparam int CW  = $clog2(MAX_TASKS + 1);
	localparam int DVW = WIDX_W + CW;
	localparam logic [HW-1:0] HEAD_EMPTY  = HW'(2**TW);
	localparam logic [HW-1:0] HEAD_CLOSED = HW'(2**TW + 1);

	logic [TC_W-1:0]   tcnt_q;
	logic [WC_W-1:0]   wcnt_q;
	logic [ST_W-1:0]   status_q [MAX_TASKS];
	logic [HW-1:0]     head_q [MAX_TASKS];
	logic [ROW_W-1:0]  dep_mem [MAX_TASKS];
	logic [HW-1:0]     link_mem [MAX_TASKS];

	logic [MODE_W-1:0] mode_q;
	logic [REQ_W-1:0]  req_q;
	logic [ROW_W-1:0]  row_in_q;
	logic [WIDX_W-1:0] widx_q;
	logic              fv_q;
	logic [REQ_W-1:0]  ft_q;
	logic [TW-1:0]     cur_q;
	logic [CW-1:0]     n_q;
	logic [HW-1:0]     node_q;
	logic [HW-1:0]     nxt_q;
	logic [ROW_W-1:0]  row_q;
	logic [ROW_W-1:0]  mask_q;
	logic              wait_cur_q;
	logic              waiting_q;
	logic              have_fwd_q;
	logic [TW-1:0]     fwd_q;
	logic              scan_q;
	logic              rb_q;
	logic              disp_q;
	logic [OUT_W-1:0]  res_outcome_q;
	logic [REQ_W-1:0]  res_task_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_outcome_q;
	logic [REQ_W-1:0]  out_task_q;

	logic [CW-1:0]     act;
	logic [WC_W-1:0]   workers;
	logic [WIDX_W-1:0] widx_sat;
	logic              req_oob;
	logic              ft_in;
	logic [TW-1:0]     t_idx;
	logic [TW-1:0]     ft_idx;
	logic [TW-1:0]     node_idx;
	logic [ROW_W-1:0]  k_src;
	logic [TW-1:0]     k_idx;
	logic              k_any;
	logic [TW-1:0]     st_idx;
	logic [TW-1:0]     hd_idx;
	logic [ST_W-1:0]   st_rd;
	logic [HW-1:0]     hd_rd;
	logic [CW-1:0]     cur_inc;
	logic [CW-1:0]     n_inc;
	logic              mask_empty;
	logic              p1_park;
	logic              p2_park;
	logic              push;
	logic              out_free;
	logic [DVW-1:0]    dividend;
	logic              div_done;
	logic [DVW-1:0]    quotient;

	assign act      = ({1'b0, tcnt_q} > 7'(MAX_TASKS)) ? CW'(MAX_TASKS) : CW'(tcnt_q);
	assign workers  = (wcnt_q == '0) ? WC_W'(1) : wcnt_q;
	assign widx_sat = ({1'b0, widx_q} >= workers) ? WIDX_W'(workers - WC_W'(1)) : widx_q;
	assign req_oob  = (7'(req_q) >= 7'(MAX_TASKS));
	assign ft_in    = (7'(ft_q) < 7'(MAX_TASKS));
	assign t_idx    = TW'(req_q);
	assign ft_idx   = TW'(ft_q);
	assign node_idx = node_q[TW-1:0];

	// rebuild picks the first dependency of the row, end steps through mask_q
	assign k_src  = rb_q ? (row_q & low_mask(7'(cur_q))) : mask_q;
	assign k_idx  = TW'(lowest_bit(k_src));
	assign k_any  = (k_src != '0);
	assign st_idx = scan_q ? cur_q : k_idx;
	assign hd_idx = disp_q ? t_idx : k_idx;
	assign st_rd  = status_q[st_idx];
	assign hd_rd  = head_q[hd_idx];

	assign cur_inc    = CW'(cur_q) + CW'(1);
	assign n_inc      = n_q + CW'(1);
	assign mask_empty = (mask_q == '0);
	assign p1_park    = (st_rd == ST_WAITING) && (hd_rd != HEAD_CLOSED);
	assign p2_park    = (st_rd != ST_DONE) && (hd_rd != HEAD_CLOSED);
	assign push       = (cmd.op == OP_RB_ROW && k_any) ||
	                    (cmd.op == OP_P1_STEP && !mask_empty && p1_park) ||
	                    (cmd.op == OP_P2_STEP && !mask_empty && p2_park);
	assign out_free   = !out_valid_q || !out_stall;

	assign dividend = DVW'(widx_sat) * DVW'(act);

	dtd_div #(
		.DVW(DVW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_DIV_START),
		.dividend (dividend),
		.divisor  (workers),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		flags.mode       = mode_q;
		flags.fwd_valid  = fv_q;
		flags.act_zero   = (act == '0);
		flags.act_le1    = (act <= CW'(1));
		flags.req_oob    = req_oob;
		flags.rb_last    = (cur_inc == act);
		flags.div_done   = div_done;
		flags.scan_hit   = (st_rd == ST_AVAILABLE);
		flags.scan_last  = (n_inc == act);
		flags.node_end   = (n_q == CW'(MAX_TASKS)) || node_q[TW];
		flags.mask_empty = mask_empty;
		flags.wait_cur   = wait_cur_q;
		flags.p1_park    = p1_park;
		flags.p2_park    = p2_park;
		flags.out_free   = out_free;
	end

	// dependency rows and watch links: one write, one registered read each
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD && !req_oob) dep_mem[t_idx] <= row_in_q;
		if (cmd.op == OP_RB_READ || cmd.op == OP_NODE_READ)
			row_q <= dep_mem[(cmd.op == OP_RB_READ) ? cur_q : node_idx];
	end

	always_ff @(posedge clk) begin
		if (push) link_mem[cur_q] <= hd_rd;
		if (cmd.op == OP_NODE_READ) nxt_q <= link_mem[node_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcnt_q        <= TC_W'(1);
			wcnt_q        <= WC_W'(1);
			for (int i = 0; i < MAX_TASKS; i++) begin
				status_q[i] <= ST_DONE;
				head_q[i]   <= HEAD_EMPTY;
			end
			mode_q        <= MODE_LOAD;
			req_q         <= '0;
			row_in_q      <= '0;
			widx_q        <= '0;
			fv_q          <= 1'b0;
			ft_q          <= '0;
			cur_q         <= '0;
			n_q           <= '0;
			node_q        <= HEAD_EMPTY;
			mask_q        <= '0;
			wait_cur_q    <= 1'b0;
			waiting_q     <= 1'b0;
			have_fwd_q    <= 1'b0;
			fwd_q         <= '0;
			scan_q        <= 1'b0;
			rb_q          <= 1'b0;
			disp_q        <= 1'b0;
			res_outcome_q <= OUT_ACK;
			res_task_q    <= '0;
			out_valid_q   <= 1'b0;
			out_outcome_q <= OUT_ACK;
			out_task_q    <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_TASK_COUNT:   tcnt_q <= cfg_data[TC_W-1:0];
					CFG_WORKER_COUNT: wcnt_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_valid_q && !out_stall && cmd.op != OP_OUT_LOAD) out_valid_q <= 1'b0;
			disp_q <= (cmd.op == OP_LATCH);

			if (push) head_q[k_idx] <= {1'b0, cur_q};

			unique case (cmd.op)
				OP_LATCH: begin
					mode_q   <= mode;
					req_q    <= task_req;
					row_in_q <= dep_row;
					widx_q   <= worker_index;
					fv_q     <= forward_valid;
					ft_q     <= forward_task;
					scan_q   <= 1'b0;
					rb_q     <= 1'b0;
				end
				OP_LOAD, OP_RES_ACK: begin
					res_outcome_q <= OUT_ACK;
					res_task_q    <= '0;
				end
				OP_RES_NONE: begin
					res_outcome_q <= OUT_NONE;
					res_task_q    <= '0;
				end
				OP_RB_INIT: begin
					for (int i = 0; i < MAX_TASKS; i++) begin
						head_q[i]   <= HEAD_EMPTY;
						status_q[i] <= (CW'(i) < act) ? ST_AVAILABLE : ST_DONE;
					end
					cur_q         <= TW'(1);
					rb_q          <= 1'b1;
					res_outcome_q <= OUT_ACK;
					res_task_q    <= '0;
				end
				OP_RB_ROW: begin
					if (k_any) status_q[cur_q] <= ST_WAITING;
					cur_q <= TW'(cur_inc);
				end
				OP_GET_FWD: begin
					if (ft_in) status_q[ft_idx] <= ST_INPROGRESS;
					res_outcome_q <= OUT_GIVEN;
					res_task_q    <= ft_q;
				end
				OP_SCAN_INIT: begin
					cur_q     <= TW'(quotient);
					n_q       <= '0;
					waiting_q <= 1'b0;
					scan_q    <= 1'b1;
				end
				OP_SCAN_STEP: begin
					if (st_rd == ST_AVAILABLE) begin
						status_q[cur_q] <= ST_INPROGRESS;
						res_outcome_q   <= OUT_GIVEN;
						res_task_q      <= REQ_W'(cur_q);
					end else begin
						if (st_rd == ST_WAITING) waiting_q <= 1'b1;
						if (n_inc == act) begin
							res_outcome_q <= (waiting_q || st_rd == ST_WAITING) ?
							                 OUT_WAIT : OUT_NONE;
							res_task_q    <= '0;
						end
					end
					cur_q <= (cur_inc == act) ? '0 : TW'(cur_inc);
					n_q   <= n_inc;
				end
				OP_END_INIT: begin
					status_q[t_idx] <= ST_DONE;
					head_q[t_idx]   <= HEAD_CLOSED;
					node_q          <= (hd_rd == HEAD_CLOSED) ? HEAD_EMPTY : hd_rd;
					n_q             <= '0;
					have_fwd_q      <= 1'b0;
					res_outcome_q   <= OUT_ACK;
					res_task_q      <= '0;
				end
				OP_END_FIN: begin
					if (have_fwd_q) begin
						res_outcome_q <= OUT_GIVEN;
						res_task_q    <= REQ_W'(fwd_q);
					end
				end
				OP_NODE_READ: begin
					cur_q <= node_idx;
				end
				OP_P1_INIT, OP_P2_INIT: begin
					mask_q <= row_q & low_mask(7'(cur_q));
					if (cmd.op == OP_P1_INIT) wait_cur_q <= 1'b0;
				end
				OP_P1_STEP: begin
					mask_q <= mask_q & (mask_q - ROW_W'(1));
					if (p1_park) begin
						node_q <= nxt_q;
						n_q    <= n_inc;
					end else if (st_rd != ST_DONE && st_rd != ST_WAITING) begin
						wait_cur_q <= 1'b1;
					end
				end
				OP_P2_STEP: begin
					mask_q <= mask_q & (mask_q - ROW_W'(1));
					if (p2_park) begin
						node_q <= nxt_q;
						n_q    <= n_inc;
					end
				end
				OP_QUEUE: begin
					// first freed watcher goes back to the caller
					if (!have_fwd_q) begin
						have_fwd_q <= 1'b1;
						fwd_q      <= cur_q;
					end else begin
						status_q[cur_q] <= ST_AVAILABLE;
					end
					node_q <= nxt_q;
					n_q    <= n_inc;
				end
				OP_OUT_LOAD: begin
					out_valid_q   <= 1'b1;
					out_outcome_q <= res_outcome_q;
					out_task_q    <= res_task_q;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign outcome   = out_outcome_q;
	assign task_id   = out_task_q;
	assign cfg_ready = 1'b1;

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT_LOAD) |-> out_free)
		else $error("result beat overwrites a pending one");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_SCAN_STEP) |-> (n_q < act && CW'(cur_q) < act))
		else $error("scan runs past active tasks");

	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_END_INIT) |=> (head_q[$past(t_idx)] == HEAD_CLOSED))
		else $error("finished task list not closed");

endmodule
